// ===== design/cloth_spring_force_and_constraint_top_defines.svh =====
// assertion macros for the cloth spring force and constraint block
// used by cloth_spring_force_and_constraint_top.sv, no other dependencies
`ifndef CLOTH_SPRING_FORCE_AND_CONSTRAINT_TOP_DEFINES_SVH
`define CLOTH_SPRING_FORCE_AND_CONSTRAINT_TOP_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define CSFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csfc: implication failed");

// next-cycle implication under synchronous active-low reset
`define CSFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csfc: next-cycle implication failed");

`endif

// ===== design/csfc_pkg.sv =====
// constants for the cloth spring force and constraint block
// no dependencies
`default_nettype none

package csfc_pkg;

    localparam logic CMD_FORCE     = 1'b0;
    localparam logic CMD_CONSTRAIN = 1'b1;

    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = 20;
    localparam int SPRING_W  = 20;
    localparam int DAMP_W    = 20;
    localparam int REST_W    = 19;

    localparam logic [REG_IDX_W-1:0] REG_SPRING = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMP   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REST   = 2'd2;

    localparam logic [SPRING_W-1:0] SPRING_RST = 20'd4096;
    localparam logic [DAMP_W-1:0]   DAMP_RST   = 20'd0;
    localparam logic [REST_W-1:0]   REST_RST   = 19'd4096;

    // tenth of rest length: (r + 5) / 10 by reciprocal multiply
    localparam int              TENTH_W     = 16;
    localparam logic [19:0]     TENTH_ROUND = 20'd5;
    localparam logic [39:0]     TENTH_RECIP = 40'd838861;
    localparam int              TENTH_SHIFT = 23;

    // length band factors, scaled by ten thousand
    localparam int              BAND_W     = 33;
    localparam logic [13:0]     BAND_SCALE = 14'd10000;
    localparam logic [13:0]     BAND_HI    = 14'd10001;
    localparam logic [13:0]     BAND_LO    = 14'd9999;

endpackage

`default_nettype wire

// ===== design/cloth_spring_force_and_constraint_top.sv =====
// cloth spring force and stretch constraint pipeline, top level
// depends on csfc_pkg and cloth_spring_force_and_constraint_top_defines.svh

// Evaluates one spring per clock cycle while no output backpressure holds it.
// The square root pipeline computes one root bit per stage, and the three-lane
// divider pipeline one bit per stage of a QW-bit quotient, QW being the
// largest of 36 - FRACTION_BITS, COMPONENT_BITS + 1 and 19. Every stage
// holds its item under output backpressure and bubbles close up, so input
// transfers continue while a result waits. Configuration is taken through a
// write port at any cycle and must only change while the pipeline is empty.
`default_nettype none
`include "cloth_spring_force_and_constraint_top_defines.svh"

module cloth_spring_force_and_constraint_top
    import csfc_pkg::*;
#(
    parameter int COMPONENT_BITS = 20,
    parameter int FRACTION_BITS  = 12
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_W-1:0]            i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_command,
    input  wire logic [3*COMPONENT_BITS-1:0] i_pos_a,
    input  wire logic [3*COMPONENT_BITS-1:0] i_pos_b,
    input  wire logic [3*COMPONENT_BITS-1:0] i_vel_a,
    input  wire logic [3*COMPONENT_BITS-1:0] i_vel_b,
    input  wire logic                        i_fixed_a,
    input  wire logic                        i_fixed_b,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [3*COMPONENT_BITS-1:0]      o_out_a,
    output logic [3*COMPONENT_BITS-1:0]      o_out_b,
    output logic                             o_saturated
);

    localparam int CB  = COMPONENT_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int SQW = 2 * CB + 2;
    localparam int RW  = CB + 1;
    localparam int PDW = DAMP_W + 1 + CB;
    localparam int HW  = PDW - FB;
    localparam int AW  = (CB + 15 > 36) ? CB + 15 : 36;
    localparam int AL  = AW / 2;
    localparam int AH  = AW - AL;
    localparam int MDW = CB + 1;
    localparam int PW  = AW + MDW;
    localparam int DVW = CB + 16;
    localparam int Q0  = (36 - FB > CB + 1) ? 36 - FB : CB + 1;
    localparam int QW  = (Q0 > 19) ? Q0 : 19;
    localparam int NW  = (PW > QW + DVW) ? PW : QW + DVW;
    localparam int X0  = (QW > HW) ? QW : HW;
    localparam int XW  = ((X0 > CB) ? X0 : CB) + 2;
    localparam int LW  = ((RW > REST_W) ? RW : REST_W) + 1;
    localparam int LKW = RW + 14;
    localparam int CW  = ((LKW > BAND_W) ? LKW : BAND_W) + 1;

    localparam logic signed [XW-1:0] CMAX = (XW'(1) << (CB - 1)) - XW'(1);
    localparam logic signed [XW-1:0] CMIN = -CMAX - XW'(1);
    localparam logic [PDW-1:0]       DBIAS = (PDW'(1) << FB) - PDW'(1);

    typedef struct packed {
        logic                cmd;
        logic                fa;
        logic                fb;
        logic [2:0][CB-1:0]  pa;
        logic [2:0][CB-1:0]  pb;
        logic [2:0][CB:0]    d;
        logic [2:0][HW-1:0]  da;
        logic [2:0][HW-1:0]  db;
    } t_side;

    typedef struct packed {
        t_side           side;
        logic            sgn;
        logic            act;
        logic [DVW-1:0]  dvsr;
    } t_dctl;

    // configuration registers and values derived from them
    logic [SPRING_W-1:0] r_spring;
    logic [DAMP_W-1:0]   r_damp;
    logic [REST_W-1:0]   r_rest;
    logic [TENTH_W-1:0]  r_tenth;
    logic [BAND_W-1:0]   r_rhi;
    logic [BAND_W-1:0]   r_rlo;
    logic [39:0]         tenth_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring <= SPRING_RST;
            r_damp   <= DAMP_RST;
            r_rest   <= REST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPRING: r_spring <= i_cfg_data[SPRING_W-1:0];
                REG_DAMP:   r_damp   <= i_cfg_data[DAMP_W-1:0];
                REG_REST:   r_rest   <= i_cfg_data[REST_W-1:0];
                default: ;
            endcase
        end
    end

    assign tenth_prod = 40'({1'b0, r_rest} + TENTH_ROUND) * TENTH_RECIP;

    always_ff @(posedge i_clk) begin
        r_tenth <= tenth_prod[TENTH_SHIFT +: TENTH_W];
        r_rhi   <= BAND_W'(r_rest) * BAND_W'(BAND_HI);
        r_rlo   <= BAND_W'(r_rest) * BAND_W'(BAND_LO);
    end

    // ready chain, back to front
    logic s1_rdy, s2_rdy, c1_rdy, c2_rdy, c3_rdy, out_rdy;
    logic sq_rdy [RW];
    logic dv_rdy [QW];
    logic r1_v, r2_v, r_c1_v, r_c2_v, r_c3_v, r_ov;
    logic r_sq_v [RW];
    logic r_dv_v [QW];

    assign out_rdy = !r_ov || i_ready;
    assign c3_rdy  = !r_c3_v || dv_rdy[0];
    assign c2_rdy  = !r_c2_v || c3_rdy;
    assign c1_rdy  = !r_c1_v || c2_rdy;
    assign s2_rdy  = !r2_v || sq_rdy[0];
    assign s1_rdy  = !r1_v || s2_rdy;
    assign o_ready = s1_rdy;

    // stage 1: differences, squares, damping products
    logic [2:0][CB-1:0]  s1_pa, s1_pb;
    logic [2:0][CB:0]    s1_d;
    logic [2:0][SQW-1:0] s1_sqr;
    logic [2:0][PDW-1:0] s1_pda, s1_pdb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_pa[i]  = i_pos_a[i*CB +: CB];
            s1_pb[i]  = i_pos_b[i*CB +: CB];
            s1_d[i]   = {s1_pa[i][CB-1], s1_pa[i]} - {s1_pb[i][CB-1], s1_pb[i]};
            s1_sqr[i] = SQW'($signed(s1_d[i]) * $signed(s1_d[i]));
            s1_pda[i] = PDW'($signed({1'b0, r_damp}) * $signed(i_vel_a[i*CB +: CB]));
            s1_pdb[i] = PDW'($signed({1'b0, r_damp}) * $signed(i_vel_b[i*CB +: CB]));
        end
    end

    logic                r1_cmd, r1_fa, r1_fb;
    logic [2:0][CB-1:0]  r1_pa, r1_pb;
    logic [2:0][CB:0]    r1_d;
    logic [2:0][SQW-1:0] r1_sqr;
    logic [2:0][PDW-1:0] r1_pda, r1_pdb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (s1_rdy) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r1_cmd <= i_command;
            r1_fa  <= i_fixed_a;
            r1_fb  <= i_fixed_b;
            r1_pa  <= s1_pa;
            r1_pb  <= s1_pb;
            r1_d   <= s1_d;
            r1_sqr <= s1_sqr;
            r1_pda <= s1_pda;
            r1_pdb <= s1_pdb;
        end
    end

    // stage 2: sum of squares, damping force rounded toward zero
    logic signed [PDW-1:0] s2_qa [3];
    logic signed [PDW-1:0] s2_qb [3];
    t_side                 s2_side;
    logic [SQW-1:0]        s2_x;

    always_comb begin
        s2_x = r1_sqr[0] + r1_sqr[1] + r1_sqr[2];
        s2_side.cmd = r1_cmd;
        s2_side.fa  = r1_fa;
        s2_side.fb  = r1_fb;
        s2_side.pa  = r1_pa;
        s2_side.pb  = r1_pb;
        s2_side.d   = r1_d;
        for (int i = 0; i < 3; i++) begin
            s2_qa[i] = r1_pda[i][PDW-1] ? $signed(r1_pda[i] + DBIAS) >>> FB
                                        : $signed(r1_pda[i]) >>> FB;
            s2_qb[i] = r1_pdb[i][PDW-1] ? $signed(r1_pdb[i] + DBIAS) >>> FB
                                        : $signed(r1_pdb[i]) >>> FB;
            s2_side.da[i] = HW'(-s2_qa[i]);
            s2_side.db[i] = HW'(-s2_qb[i]);
        end
    end

    t_side          r2_side;
    logic [SQW-1:0] r2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s2_rdy) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r1_v) begin
            r2_side <= s2_side;
            r2_x    <= s2_x;
        end
    end

    // square root pipeline, one root bit per stage
    t_side          r_sq_side [RW];
    logic [SQW-1:0] r_sq_x    [RW];
    logic [RW-1:0]  r_sq_root [RW];
    logic [RW+1:0]  r_sq_rem  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_sq
        logic          pv;
        t_side         ps;
        logic [SQW-1:0] px;
        logic [RW-1:0] proot;
        logic [RW+1:0] prem;
        logic          nrdy;
        logic [RW+2:0] sh, trial, dif;
        logic          ge;

        if (k == 0) begin : g_first
            assign pv    = r2_v;
            assign ps    = r2_side;
            assign px    = r2_x;
            assign proot = '0;
            assign prem  = '0;
        end else begin : g_next
            assign pv    = r_sq_v[k-1];
            assign ps    = r_sq_side[k-1];
            assign px    = r_sq_x[k-1];
            assign proot = r_sq_root[k-1];
            assign prem  = r_sq_rem[k-1];
        end

        if (k == RW - 1) begin : g_last
            assign nrdy = c1_rdy;
        end else begin : g_mid
            assign nrdy = sq_rdy[k+1];
        end

        assign sq_rdy[k] = !r_sq_v[k] || nrdy;
        assign sh        = {prem[RW:0], px[SQW-1-2*k -: 2]};
        assign trial     = {1'b0, proot, 2'b01};
        assign ge        = sh >= trial;
        assign dif       = sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (sq_rdy[k]) begin
                r_sq_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (sq_rdy[k] && pv) begin
                r_sq_side[k] <= ps;
                r_sq_x[k]    <= px;
                r_sq_root[k] <= {proot[RW-2:0], ge};
                r_sq_rem[k]  <= ge ? dif[RW+1:0] : sh[RW+1:0];
            end
        end
    end

    // stage c1: clamped length error or band correction, divisor
    logic [RW-1:0]        c1_l;
    logic signed [LW-1:0] c1_diff, c1_tn, c1_dl;
    logic [LW-1:0]        c1_dmag;
    logic                 c1_dneg;
    logic [SPRING_W+TENTH_W-1:0] c1_af;
    logic [LKW-1:0]       c1_lk;
    logic                 c1_gt, c1_lt, c1_sneg;
    logic signed [CW-1:0] c1_s;
    logic [CW-1:0]        c1_smag;
    t_dctl                c1_n;
    logic [AW-1:0]        c1_na;

    always_comb begin
        c1_l    = r_sq_root[RW-1];
        c1_diff = $signed(LW'(c1_l)) - $signed(LW'(r_rest));
        c1_tn   = $signed(LW'(r_tenth));
        if (c1_diff > c1_tn) begin
            c1_dl = c1_tn;
        end else if (c1_diff < -c1_tn) begin
            c1_dl = -c1_tn;
        end else begin
            c1_dl = c1_diff;
        end
        c1_dneg = c1_dl[LW-1];
        c1_dmag = c1_dneg ? -c1_dl : c1_dl;
        c1_af   = r_spring * c1_dmag[TENTH_W-1:0];
        c1_lk   = LKW'(c1_l) * LKW'(BAND_SCALE);
        c1_gt   = CW'(c1_lk) > CW'(r_rhi);
        c1_lt   = CW'(c1_lk) < CW'(r_rlo);
        c1_s    = c1_gt ? $signed(CW'(c1_lk)) - $signed(CW'(r_rhi))
                        : $signed(CW'(c1_lk)) - $signed(CW'(r_rlo));
        c1_sneg = c1_s[CW-1];
        c1_smag = c1_sneg ? -c1_s : c1_s;
        c1_n.side = r_sq_side[RW-1];
        if (r_sq_side[RW-1].cmd == CMD_FORCE) begin
            c1_n.sgn  = c1_dneg;
            c1_n.act  = c1_l != '0;
            c1_n.dvsr = DVW'(c1_l);
            c1_na     = AW'(c1_af);
        end else begin
            c1_n.sgn  = c1_sneg;
            c1_n.act  = !(r_sq_side[RW-1].fa && r_sq_side[RW-1].fb) && (c1_l != '0)
                        && (c1_gt || c1_lt);
            // both ends free: each takes half of the move
            c1_n.dvsr = (!r_sq_side[RW-1].fa && !r_sq_side[RW-1].fb) ? DVW'({c1_lk, 1'b0})
                                                                    : DVW'(c1_lk);
            c1_na     = AW'(c1_smag);
        end
    end

    t_dctl         r_c1;
    logic [AW-1:0] r_c1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else if (c1_rdy) begin
            r_c1_v <= r_sq_v[RW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c1_rdy && r_sq_v[RW-1]) begin
            r_c1   <= c1_n;
            r_c1_a <= c1_na;
        end
    end

    // stage c2: magnitude times |d| as two partial products per lane
    logic [2:0][MDW-1:0]    c2_ad;
    logic [2:0][AL+MDW-1:0] c2_plo;
    logic [2:0][AH+MDW-1:0] c2_phi;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_ad[i]  = r_c1.side.d[i][CB] ? -r_c1.side.d[i] : r_c1.side.d[i];
            c2_plo[i] = r_c1_a[AL-1:0] * c2_ad[i];
            c2_phi[i] = r_c1_a[AW-1:AL] * c2_ad[i];
        end
    end

    t_dctl                  r_c2;
    logic [2:0][AL+MDW-1:0] r_c2_plo;
    logic [2:0][AH+MDW-1:0] r_c2_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_v <= 1'b0;
        end else if (c2_rdy) begin
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c2_rdy && r_c1_v) begin
            r_c2     <= r_c1;
            r_c2_plo <= c2_plo;
            r_c2_phi <= c2_phi;
        end
    end

    // stage c3: combine partial products, drop fraction bits in force mode
    logic [2:0][PW-1:0] c3_p;
    logic [2:0][NW-1:0] c3_n;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c3_p[i] = (PW'(r_c2_phi[i]) << AL) + PW'(r_c2_plo[i]);
            c3_n[i] = (r_c2.side.cmd == CMD_FORCE) ? NW'(c3_p[i] >> FB) : NW'(c3_p[i]);
        end
    end

    t_dctl              r_c3;
    logic [2:0][NW-1:0] r_c3_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_v <= 1'b0;
        end else if (c3_rdy) begin
            r_c3_v <= r_c2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c3_rdy && r_c2_v) begin
            r_c3   <= r_c2;
            r_c3_n <= c3_n;
        end
    end

    // restoring divider, three lanes sharing one divisor, one bit per stage
    t_dctl               r_dv_ctl [QW];
    logic [2:0][DVW-1:0] r_dv_rem [QW];
    logic [2:0][QW-1:0]  r_dv_nq  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_dv
        logic                pv;
        t_dctl               pc;
        logic [2:0][DVW-1:0] prem;
        logic [2:0][QW-1:0]  pnq;
        logic                nrdy;
        logic [2:0][DVW:0]   sh, dif;
        logic [2:0]          ge;
        logic [2:0][DVW-1:0] nrem;
        logic [2:0][QW-1:0]  nnq;

        if (j == 0) begin : g_first
            assign pv = r_c3_v;
            assign pc = r_c3;
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign prem[l] = DVW'(r_c3_n[l][NW-1:QW]);
                assign pnq[l]  = r_c3_n[l][QW-1:0];
            end
        end else begin : g_next
            assign pv   = r_dv_v[j-1];
            assign pc   = r_dv_ctl[j-1];
            assign prem = r_dv_rem[j-1];
            assign pnq  = r_dv_nq[j-1];
        end

        if (j == QW - 1) begin : g_last
            assign nrdy = out_rdy;
        end else begin : g_mid
            assign nrdy = dv_rdy[j+1];
        end

        assign dv_rdy[j] = !r_dv_v[j] || nrdy;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                sh[l]   = {prem[l], pnq[l][QW-1]};
                dif[l]  = sh[l] - {1'b0, pc.dvsr};
                ge[l]   = sh[l] >= {1'b0, pc.dvsr};
                nrem[l] = ge[l] ? dif[l][DVW-1:0] : sh[l][DVW-1:0];
                nnq[l]  = {pnq[l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (dv_rdy[j]) begin
                r_dv_v[j] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (dv_rdy[j] && pv) begin
                r_dv_ctl[j] <= pc;
                r_dv_rem[j] <= nrem;
                r_dv_nq[j]  <= nnq;
            end
        end
    end

    // output stage: apply sign, add damping or position, saturate
    t_dctl                fo_c;
    logic signed [XW-1:0] fo_q   [3];
    logic signed [XW-1:0] fo_sv  [3];
    logic signed [XW-1:0] fo_va  [3];
    logic signed [XW-1:0] fo_vb  [3];
    logic [2:0]           fo_neg;
    logic [3*CB-1:0]      fo_a, fo_b;
    logic                 fo_sat;

    always_comb begin
        fo_c   = r_dv_ctl[QW-1];
        fo_sat = 1'b0;
        fo_a   = '0;
        fo_b   = '0;
        for (int i = 0; i < 3; i++) begin
            fo_q[i]   = XW'($signed({1'b0, r_dv_nq[QW-1][i]}));
            fo_neg[i] = fo_c.sgn ^ fo_c.side.d[i][CB] ^ (fo_c.side.cmd == CMD_CONSTRAIN);
            if (!fo_c.act) begin
                fo_sv[i] = '0;
            end else begin
                fo_sv[i] = fo_neg[i] ? -fo_q[i] : fo_q[i];
            end
            if (fo_c.side.cmd == CMD_FORCE) begin
                fo_va[i] = XW'($signed(fo_c.side.da[i])) - fo_sv[i];
                fo_vb[i] = XW'($signed(fo_c.side.db[i])) + fo_sv[i];
            end else begin
                fo_va[i] = fo_c.side.fa ? XW'($signed(fo_c.side.pa[i]))
                                        : XW'($signed(fo_c.side.pa[i])) + fo_sv[i];
                fo_vb[i] = fo_c.side.fb ? XW'($signed(fo_c.side.pb[i]))
                                        : XW'($signed(fo_c.side.pb[i])) - fo_sv[i];
            end
            if (fo_va[i] > CMAX) begin
                fo_a[i*CB +: CB] = CMAX[CB-1:0];
                fo_sat = 1'b1;
            end else if (fo_va[i] < CMIN) begin
                fo_a[i*CB +: CB] = CMIN[CB-1:0];
                fo_sat = 1'b1;
            end else begin
                fo_a[i*CB +: CB] = fo_va[i][CB-1:0];
            end
            if (fo_vb[i] > CMAX) begin
                fo_b[i*CB +: CB] = CMAX[CB-1:0];
                fo_sat = 1'b1;
            end else if (fo_vb[i] < CMIN) begin
                fo_b[i*CB +: CB] = CMIN[CB-1:0];
                fo_sat = 1'b1;
            end else begin
                fo_b[i*CB +: CB] = fo_vb[i][CB-1:0];
            end
        end
    end

    logic [3*CB-1:0] r_out_a, r_out_b;
    logic            r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= r_dv_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_dv_v[QW-1]) begin
            r_out_a <= fo_a;
            r_out_b <= fo_b;
            r_sat   <= fo_sat;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_saturated = r_sat;

    // root leaving the last stage is the floor square root of the sum
    `CSFC_ASSERT_IMP(a_sqrt_floor, i_clk, i_rst_n, r_sq_v[RW-1], (SQW'(r_sq_root[RW-1]) * SQW'(r_sq_root[RW-1]) <= r_sq_x[RW-1]) && ((SQW+1)'(r_sq_root[RW-1] + 1'b1) * (SQW+1)'(r_sq_root[RW-1] + 1'b1) > (SQW+1)'(r_sq_x[RW-1])))
    // an active division never sees a zero divisor
    `CSFC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_c1_v && r_c1.act, r_c1.dvsr != '0)
    // a stalled stage keeps its item
    `CSFC_ASSERT_NXT(a_c1_hold, i_clk, i_rst_n, r_c1_v && !c1_rdy, r_c1_v && $stable(r_c1_a))

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for cloth_spring_force_and_constraint_top
// depends on csfc_pkg and the design sources; predicts forces and constrained positions
`timescale 1ns / 1ps

class spring_scoreboard;
    logic [59:0] exp_a_q[$];
    logic [59:0] exp_b_q[$];
    bit          exp_sat_q[$];
    int          errors;
    int          checks;

    function void note_spring(logic [59:0] a, logic [59:0] b, bit sat);
        exp_a_q.push_back(a);
        exp_b_q.push_back(b);
        exp_sat_q.push_back(sat);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task check_result(logic [59:0] a, logic [59:0] b, bit sat);
        logic [59:0] ea;
        logic [59:0] eb;
        bit          es;
        if (exp_a_q.size() == 0) begin
            report($sformatf("unexpected result a=%h b=%h", a, b));
            return;
        end
        ea = exp_a_q.pop_front();
        eb = exp_b_q.pop_front();
        es = exp_sat_q.pop_front();
        checks++;
        if (a !== ea) report($sformatf("out_a %h expected %h", a, ea));
        if (b !== eb) report($sformatf("out_b %h expected %h", b, eb));
        if (sat !== es) report($sformatf("saturated %0b expected %0b", sat, es));
    endtask

    function int pending();
        return exp_a_q.size();
    endfunction
endclass

module tb_top
    import csfc_pkg::*;
();

    localparam int CB        = 20;
    localparam int FB        = 12;
    localparam int DRAIN_CYC = 80;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_command = CMD_FORCE;
    logic [3*CB-1:0]      i_pos_a = '0;
    logic [3*CB-1:0]      i_pos_b = '0;
    logic [3*CB-1:0]      i_vel_a = '0;
    logic [3*CB-1:0]      i_vel_b = '0;
    logic                 i_fixed_a = 1'b0;
    logic                 i_fixed_b = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [3*CB-1:0]      o_out_a;
    logic [3*CB-1:0]      o_out_b;
    logic                 o_saturated;

    longint unsigned spring_k;
    longint unsigned damp_k;
    longint unsigned rest_len;

    spring_scoreboard sb;

    cloth_spring_force_and_constraint_top #(
        .COMPONENT_BITS(CB),
        .FRACTION_BITS (FB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_pos_a    (i_pos_a),
        .i_pos_b    (i_pos_b),
        .i_vel_a    (i_vel_a),
        .i_vel_b    (i_vel_b),
        .i_fixed_a  (i_fixed_a),
        .i_fixed_b  (i_fixed_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_a    (o_out_a),
        .o_out_b    (o_out_b),
        .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint comp_of(logic [59:0] w, int i);
        logic signed [CB-1:0] c;
        c = w[i*CB +: CB];
        return longint'(c);
    endfunction

    function automatic logic [CB-1:0] clamp_comp(longint v, ref bit sat);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CB - 1)) - 1;
        lo = -(longint'(1) << (CB - 1));
        if (v > hi) begin
            v = hi;
            sat = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            sat = 1'b1;
        end
        return v[CB-1:0];
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint damping_of(longint v);
        longint p;
        p = longint'(damp_k) * v;
        return -(p / (longint'(1) << FB));
    endfunction

    // expected outputs for one spring, computed with the current registers
    task automatic predict_spring(logic cmd, logic [59:0] pa, logic [59:0] pb,
                                  logic [59:0] va, logic [59:0] vb, logic fa, logic fb);
        longint          d[3];
        longint          a_c[3];
        longint          b_c[3];
        longint unsigned sq;
        longint          len;
        longint          rl;
        longint          delta;
        longint          tenth;
        longint          sp;
        longint          s;
        longint          dv;
        longint          m;
        bit              move;
        bit              sat;
        logic [59:0]     ra;
        logic [59:0]     rb;
        sq = 0;
        sat = 1'b0;
        rl = longint'(rest_len);
        for (int i = 0; i < 3; i++) begin
            a_c[i] = comp_of(pa, i);
            b_c[i] = comp_of(pb, i);
            d[i] = a_c[i] - b_c[i];
            sq += longint'(d[i] * d[i]);
        end
        len = longint'(isqrt(sq));
        if (cmd == CMD_FORCE) begin
            tenth = (rl + 5) / 10;
            delta = len - rl;
            if (delta > tenth) delta = tenth;
            if (delta < -tenth) delta = -tenth;
            for (int i = 0; i < 3; i++) begin
                sp = 0;
                if (len != 0)
                    sp = (longint'(spring_k) * delta * d[i]) / (len * (longint'(1) << FB));
                ra[i*CB +: CB] = clamp_comp(-sp + damping_of(comp_of(va, i)), sat);
                rb[i*CB +: CB] = clamp_comp(sp + damping_of(comp_of(vb, i)), sat);
            end
        end else begin
            s = 0;
            move = 1'b0;
            if (!(fa && fb) && len != 0) begin
                if (10000 * len > 10001 * rl) begin
                    s = 10000 * len - 10001 * rl;
                    move = 1'b1;
                end else if (10000 * len < 9999 * rl) begin
                    s = 10000 * len - 9999 * rl;
                    move = 1'b1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (move) begin
                    dv = 10000 * len * ((!fa && !fb) ? 2 : 1);
                    m = (s * (-d[i])) / dv;
                    if (!fa) a_c[i] += m;
                    if (!fb) b_c[i] -= m;
                end
                ra[i*CB +: CB] = clamp_comp(a_c[i], sat);
                rb[i*CB +: CB] = clamp_comp(b_c[i], sat);
            end
        end
        sb.note_spring(ra, rb, sat);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_SPRING: spring_k = val;
            REG_DAMP:   damp_k = val;
            REG_REST:   rest_len = val[REST_W-1:0];
            default: ;
        endcase
    endtask

    // valid stays high into the next item when it follows with no gap
    task automatic send_spring(logic cmd, logic [59:0] pa, logic [59:0] pb,
                               logic [59:0] va, logic [59:0] vb, logic fa, logic fb);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_pos_a   <= pa;
        i_pos_b   <= pb;
        i_vel_a   <= va;
        i_vel_b   <= vb;
        i_fixed_a <= fa;
        i_fixed_b <= fb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_spring(cmd, pa, pb, va, vb, fa, fb);
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [59:0] pack3(longint x, longint y, longint z);
        logic [59:0] w;
        w[0 +: CB]    = x[CB-1:0];
        w[CB +: CB]   = y[CB-1:0];
        w[2*CB +: CB] = z[CB-1:0];
        return w;
    endfunction

    function automatic logic [59:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[59:0];
    endfunction

    function automatic longint small_comp(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // spring near rest length: random direction scaled to about rest_len
    task automatic send_near_rest(logic cmd);
        longint      x;
        longint      y;
        longint      z;
        longint      n;
        longint      bx;
        longint      by;
        longint      bz;
        logic [59:0] pa;
        x = small_comp(4096);
        y = small_comp(4096);
        z = small_comp(4096);
        n = longint'(isqrt(x * x + y * y + z * z));
        if (n == 0) n = 1;
        pa = pack3(small_comp(100000), small_comp(100000), small_comp(100000));
        bx = comp_of(pa, 0) - x * longint'(rest_len) * (900 + $urandom_range(0, 200)) / (n * 1000);
        by = comp_of(pa, 1) - y * longint'(rest_len) / n;
        bz = comp_of(pa, 2) - z * longint'(rest_len) / n;
        send_spring(cmd, pa, pack3(bx, by, bz), rand_word() & {3{20'h0FFFF}},
                    rand_word(), $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic directed_phase();
        logic [59:0] mx;
        logic [59:0] mn;
        mx = pack3(524287, 524287, 524287);
        mn = pack3(-524288, -524288, -524288);
        // zero length in both modes
        send_spring(CMD_FORCE, pack3(5, 6, 7), pack3(5, 6, 7), mx, mn, 1'b0, 1'b0);
        send_spring(CMD_CONSTRAIN, pack3(5, 6, 7), pack3(5, 6, 7), '0, '0, 1'b0, 1'b0);
        // extremes: far apart, saturate
        send_spring(CMD_FORCE, mx, mn, mx, mn, 1'b1, 1'b1);
        send_spring(CMD_FORCE, mn, mx, mn, mx, 1'b0, 1'b1);
        send_spring(CMD_CONSTRAIN, mx, mn, mx, mn, 1'b0, 1'b0);
        send_spring(CMD_CONSTRAIN, mn, mx, '0, '0, 1'b1, 1'b0);
        send_spring(CMD_CONSTRAIN, mx, mn, '0, '0, 1'b0, 1'b1);
        // both pinned
        send_spring(CMD_CONSTRAIN, pack3(9000, 0, 0), '0, '0, '0, 1'b1, 1'b1);
        // within the band, exactly rest length
        send_spring(CMD_CONSTRAIN, pack3(longint'(rest_len), 0, 0), '0, '0, '0, 1'b0, 1'b0);
        send_spring(CMD_FORCE, pack3(0, longint'(rest_len), 0), '0, mx, mn, 1'b0, 1'b0);
        // too short, too long, each pinning combination
        send_spring(CMD_CONSTRAIN, pack3(2000, 0, 0), '0, mx, '0, 1'b0, 1'b0);
        send_spring(CMD_CONSTRAIN, pack3(0, 9000, 0), '0, '0, '0, 1'b1, 1'b0);
        send_spring(CMD_CONSTRAIN, pack3(0, 0, -9000), '0, '0, '0, 1'b0, 1'b1);
        send_spring(CMD_FORCE, pack3(0, 0, -4200), '0, pack3(1, -1, 0), '0, 1'b1, 1'b0);
        send_spring(CMD_FORCE, pack3(-3000, 0, 0), '0, pack3(100, 0, -100), '0, 1'b0, 1'b0);
    endtask

    task automatic random_phase(int n);
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                send_near_rest($urandom_range(0, 1));
            end else if (kind < 8) begin
                send_spring($urandom_range(0, 1),
                            pack3(small_comp(30000), small_comp(30000), small_comp(30000)),
                            pack3(small_comp(30000), small_comp(30000), small_comp(30000)),
                            pack3(small_comp(20000), small_comp(20000), small_comp(20000)),
                            pack3(small_comp(20000), small_comp(20000), small_comp(20000)),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                send_spring($urandom_range(0, 1), rand_word(), rand_word(), rand_word(),
                            rand_word(), $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    // result side: random stalls with occasional long ready stretches
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_out_a, o_out_b, o_saturated);
    end

    initial begin
        sb = new();
        spring_k = SPRING_RST;
        damp_k = DAMP_RST;
        rest_len = REST_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_phase();
        drain();
        write_reg(REG_DAMP, 20'd2048);
        write_reg(REG_SPRING, 20'd40960);
        random_phase(300);
        drain();
        write_reg(REG_SPRING, 20'hFFFFF);
        write_reg(REG_DAMP, 20'hFFFFF);
        write_reg(REG_REST, 20'h7FFFF);
        directed_phase();
        random_phase(300);
        drain();
        write_reg(REG_SPRING, '0);
        write_reg(REG_DAMP, '0);
        write_reg(REG_REST, '0);
        directed_phase();
        random_phase(200);
        drain();
        write_reg(REG_SPRING, 20'd1000 + 20'($urandom_range(0, 20000)));
        write_reg(REG_DAMP, 20'($urandom_range(0, 8192)));
        write_reg(REG_REST, 20'd10 + 20'($urandom_range(0, 30000)));
        random_phase(350);
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (sb.pending() != 0) sb.report("expected results never arrived");
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/csfc_pkg.sv
design/cloth_spring_force_and_constraint_top.sv
sim/tb_top.sv
